FILE: hw/rtl/masked_region_address_decoder_core_macros.svh
// assertion macros for the masked region address decoder checker
// no dependencies; included by the checker file
`ifndef MASKED_REGION_ADDRESS_DECODER_CORE_MACROS_SVH
`define MASKED_REGION_ADDRESS_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MRAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mrad_pkg.sv
// shared types, constants and status codes of the masked region address decoder
// no dependencies
package mrad_pkg;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int ADDR_W          = 32;
    localparam int TAG_W           = 8;
    localparam int BYTES_W         = 4;
    localparam int STATUS_W        = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED   = 3'd0,
        ST_FALLBACK = 3'd1,
        ST_UNMAPPED = 3'd2,
        ST_ADDED    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_ACCESS = 1'b1
    } t_kind;

    // one table entry as stored in the region ram
    typedef struct packed {
        logic [ADDR_W-1:0] bound_low;
        logic [ADDR_W-1:0] bound_high;
        logic [ADDR_W-1:0] compare_mask;
        logic [ADDR_W-1:0] offset_mask;
        logic [TAG_W-1:0]  target;
    } t_region;

    // verdict of the shared compare unit on one entry
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] local_addr;
    } t_match;

endpackage

FILE: hw/rtl/mrad_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mrad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/mrad_match.sv
// shared compare unit: checks one region entry against an access span
// depends on mrad_pkg
module mrad_match
    import mrad_pkg::*;
(
    input  logic [ADDR_W-1:0] i_start,
    input  logic [ADDR_W-1:0] i_end,
    input  t_region           i_entry,
    output t_match            o_match
);

    logic [ADDR_W-1:0] start_masked;
    logic [ADDR_W-1:0] end_masked;

    assign start_masked = i_start & i_entry.compare_mask;
    assign end_masked   = i_end & i_entry.compare_mask;

    assign o_match.hit        = (start_masked >= i_entry.bound_low) &&
                                (end_masked <= i_entry.bound_high);
    assign o_match.local_addr = i_start & i_entry.offset_mask;

endmodule

FILE: hw/rtl/masked_region_address_decoder_core.sv
// an access steps through accept, a scan of the table entries one entry per cycle out of the
// single region ram read port feeding the compare, stopping at the first hit, and hand-over
// of the result to the output register; an add, or an access on an empty table, skips the scan
// one request at a time: no new request until the result is handed over, which waits on a stall
// reset (synchronous, active low) clears the region count, fallback bit and control state;
// table contents are undefined until written and get no clearing pass
module masked_region_address_decoder_core
    import mrad_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [BYTES_W-1:0]  i_access_bytes,
    input  logic                i_is_write,
    input  logic [ADDR_W-1:0]   i_region_first,
    input  logic [ADDR_W-1:0]   i_region_last,
    input  logic [ADDR_W-1:0]   i_region_range_mask,
    input  logic [ADDR_W-1:0]   i_region_local_mask,
    input  logic [TAG_W-1:0]    i_region_tag,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TAG_W-1:0]    o_target_tag,
    output logic [ADDR_W-1:0]   o_local_address,
    output logic                o_write_out,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    // one-hot sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_fallback, n_fallback;

    // access under decode
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_end, n_end;
    logic               r_wr, n_wr;

    // finished result waiting for the output register
    t_status            r_res_status, n_res_status;
    logic [TAG_W-1:0]   r_res_tag, n_res_tag;
    logic [ADDR_W-1:0]  r_res_local, n_res_local;
    logic               r_res_wr, n_res_wr;

    // output register
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [ADDR_W-1:0]  r_out_local, n_out_local;
    logic               r_out_wr, n_out_wr;

    logic               in_accept;
    logic               table_full;
    logic               last_entry;
    logic               slot_free;
    logic               ram_wr_en;
    t_region            ram_wr_data;
    t_region            ram_rd_data;
    t_match             match;
    t_status            miss_status;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign table_full = (r_count >= CNT_W'(MAX_REGIONS));
    assign last_entry = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign miss_status = r_fallback ? ST_FALLBACK : ST_UNMAPPED;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    // new region goes in at the fill point
    assign ram_wr_en = in_accept && (t_kind'(i_kind) == KIND_ADD) && !table_full;
    assign ram_wr_data = '{
        bound_low:    i_region_first,
        bound_high:   i_region_last,
        compare_mask: i_region_range_mask,
        offset_mask:  i_region_local_mask,
        target:       i_region_tag
    };

    mrad_ram #(
        .WIDTH ($bits(t_region)),
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (ram_rd_data)
    );

    // ram data in S_SCAN is always the entry at r_idx
    mrad_match u_match (
        .i_start (r_addr),
        .i_end   (r_end),
        .i_entry (ram_rd_data),
        .o_match (match)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_fallback   = r_fallback;
        n_addr       = r_addr;
        n_end        = r_end;
        n_wr         = r_wr;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_res_local  = r_res_local;
        n_res_wr     = r_res_wr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_local  = r_out_local;
        n_out_wr     = r_out_wr;

        if (i_cfg_valid) begin
            n_fallback = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_idx  = '0;
                    n_addr = i_address;
                    // span end wraps at 32 bits
                    n_end  = i_address + ADDR_W'(i_access_bytes) - ADDR_W'(1);
                    n_wr   = i_is_write;
                    n_state = S_DONE;
                    if (t_kind'(i_kind) == KIND_ADD) begin
                        n_res_tag   = '0;
                        n_res_local = '0;
                        n_res_wr    = 1'b0;
                        if (table_full) begin
                            n_res_status = ST_OVERFLOW;
                        end else begin
                            n_res_status = ST_ADDED;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        // empty table, straight to a miss
                        n_res_status = miss_status;
                        n_res_tag    = '0;
                        n_res_local  = i_address;
                        n_res_wr     = i_is_write;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (match.hit) begin
                    n_res_status = ST_MAPPED;
                    n_res_tag    = ram_rd_data.target;
                    n_res_local  = match.local_addr;
                    n_res_wr     = r_wr;
                    n_state      = S_DONE;
                end else if (last_entry) begin
                    n_res_status = miss_status;
                    n_res_tag    = '0;
                    n_res_local  = r_addr;
                    n_res_wr     = r_wr;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                // hand over once the output register is free or being drained
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_tag    = r_res_tag;
                    n_out_local  = r_res_local;
                    n_out_wr     = r_res_wr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_fallback  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_fallback  <= n_fallback;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_end        <= n_end;
        r_wr         <= n_wr;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_res_local  <= n_res_local;
        r_res_wr     <= n_res_wr;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
        r_out_local  <= n_out_local;
        r_out_wr     <= n_out_wr;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_target_tag    = r_out_tag;
    assign o_local_address = r_out_local;
    assign o_write_out     = r_out_wr;

endmodule

FILE: hw/rtl/mrad_checker.sv
// port-level checker for the masked region address decoder, bound to the top level
// depends on mrad_pkg and masked_region_address_decoder_core_macros.svh
`include "masked_region_address_decoder_core_macros.svh"

module mrad_checker
    import mrad_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [TAG_W-1:0]    o_target_tag,
    input logic [ADDR_W-1:0]   o_local_address,
    input logic                o_write_out
);

    logic                             in_acc;
    logic                             add_res;
    logic                             add_clear;
    logic                             miss_res;
    logic                             out_hold;
    logic [STATUS_W+TAG_W+ADDR_W+1:0] out_word;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign add_res   = o_out_valid && (o_status == ST_ADDED || o_status == ST_OVERFLOW);
    assign add_clear = (o_target_tag == '0) && (o_local_address == '0) && !o_write_out;
    assign miss_res  = o_out_valid && (o_status == ST_FALLBACK || o_status == ST_UNMAPPED);
    assign out_hold  = o_out_valid && i_out_stall;
    assign out_word  = {o_out_valid, o_status, o_target_tag, o_local_address, o_write_out};

    // one request at a time: busy right after taking one
    `MRAD_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_acc, o_in_stall, "not busy after a request")

    // add results carry no tag, offset or write flag
    `MRAD_ASSERT_NOW(a_add_clear, i_clk, i_rst_n, add_res, add_clear, "add result with payload")

    // unmatched accesses carry no tag
    `MRAD_ASSERT_NOW(a_miss_tag, i_clk, i_rst_n, miss_res, o_target_tag == '0, "tag on a miss")

    // a stalled result holds
    `MRAD_ASSERT_NXT(a_held, i_clk, i_rst_n, out_hold, $stable(out_word), "stalled result changed")

endmodule

bind masked_region_address_decoder_core mrad_checker u_mrad_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_target_tag    (o_target_tag),
    .o_local_address (o_local_address),
    .o_write_out     (o_write_out)
);
